@@ rtl/core/rtnh_pkg.sv @@
package rtnh_pkg;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z    = 3'd5;

  localparam int NUM_CFG  = 6;
  localparam int NUM_VTX  = 9;
  localparam int NUM_LOAD = NUM_VTX + NUM_CFG;
  localparam int DIST_OUT_W = 30;
  localparam int DIST_INT = 10000;

  localparam int SLOT_W = 6;
  localparam int PC_W = 5;
  localparam int SUB_W = 4;
  localparam logic [PC_W-1:0] PC_LAST = 5'd24;

  // Scratch slots of the operand memory.
  localparam logic [SLOT_W-1:0] R_A   = 6'd0;
  localparam logic [SLOT_W-1:0] R_B   = 6'd3;
  localparam logic [SLOT_W-1:0] R_C   = 6'd6;
  localparam logic [SLOT_W-1:0] R_O   = 6'd9;
  localparam logic [SLOT_W-1:0] R_D   = 6'd12;
  localparam logic [SLOT_W-1:0] R_T1  = 6'd15;
  localparam logic [SLOT_W-1:0] R_T2  = 6'd16;
  localparam logic [SLOT_W-1:0] R_E1  = 6'd17;
  localparam logic [SLOT_W-1:0] R_E2  = 6'd20;
  localparam logic [SLOT_W-1:0] R_N   = 6'd23;
  localparam logic [SLOT_W-1:0] R_DEN = 6'd26;
  localparam logic [SLOT_W-1:0] R_W   = 6'd27;
  localparam logic [SLOT_W-1:0] R_NUM = 6'd30;
  localparam logic [SLOT_W-1:0] R_T   = 6'd31;
  localparam logic [SLOT_W-1:0] R_P   = 6'd32;
  localparam logic [SLOT_W-1:0] R_F   = 6'd35;
  localparam logic [SLOT_W-1:0] R_G   = 6'd38;
  localparam logic [SLOT_W-1:0] R_U   = 6'd41;
  localparam logic [SLOT_W-1:0] R_H   = 6'd44;
  localparam logic [SLOT_W-1:0] R_K   = 6'd47;
  localparam logic [SLOT_W-1:0] R_V   = 6'd50;
  localparam logic [SLOT_W-1:0] R_DOT = 6'd53;
  localparam logic [SLOT_W-1:0] R_M   = 6'd54;
  localparam logic [SLOT_W-1:0] R_W2  = 6'd57;

  typedef enum logic [3:0] {
    M_LOAD, M_VSUB, M_VADD, M_SMUL, M_CROSS, M_DOT, M_FNN, M_FNEG, M_DIV, M_HIT
  } mop_t;

  typedef enum logic [2:0] {
    B_LD, B_SUB, B_ADD, B_MUL, B_FNN, B_FNEG, B_DIV, B_HIT
  } bop_t;

  typedef struct packed {
    mop_t              op;
    logic [SLOT_W-1:0] dst;
    logic [SLOT_W-1:0] a;
    logic [SLOT_W-1:0] b;
  } minst_t;

  typedef struct packed {
    bop_t              kind;
    logic [SLOT_W-1:0] dst;
    logic [SLOT_W-1:0] ra;
    logic [SLOT_W-1:0] rb;
    logic              last;
  } uop_t;

  function automatic minst_t mi(input mop_t op, input logic [SLOT_W-1:0] dst,
                                input logic [SLOT_W-1:0] a, input logic [SLOT_W-1:0] b);
    minst_t m;
    m.op = op;
    m.dst = dst;
    m.a = a;
    m.b = b;
    return m;
  endfunction

  function automatic minst_t prog(input logic [PC_W-1:0] pc);
    minst_t m;
    case (pc)
      5'd0:    m = mi(M_LOAD,  R_A,   R_A,   R_A);
      5'd1:    m = mi(M_VSUB,  R_E1,  R_B,   R_A);
      5'd2:    m = mi(M_VSUB,  R_E2,  R_C,   R_A);
      5'd3:    m = mi(M_CROSS, R_N,   R_E1,  R_E2);
      5'd4:    m = mi(M_DOT,   R_DEN, R_N,   R_D);
      5'd5:    m = mi(M_FNN,   R_DEN, R_DEN, R_DEN);
      5'd6:    m = mi(M_VSUB,  R_W,   R_A,   R_O);
      5'd7:    m = mi(M_DOT,   R_NUM, R_N,   R_W);
      5'd8:    m = mi(M_FNN,   R_NUM, R_NUM, R_NUM);
      5'd9:    m = mi(M_DIV,   R_T,   R_NUM, R_DEN);
      5'd10:   m = mi(M_SMUL,  R_P,   R_D,   R_T);
      5'd11:   m = mi(M_VADD,  R_P,   R_O,   R_P);
      5'd12:   m = mi(M_VSUB,  R_F,   R_C,   R_B);
      5'd13:   m = mi(M_VSUB,  R_G,   R_P,   R_C);
      5'd14:   m = mi(M_CROSS, R_U,   R_F,   R_G);
      5'd15:   m = mi(M_VSUB,  R_H,   R_A,   R_C);
      5'd16:   m = mi(M_VSUB,  R_K,   R_P,   R_A);
      5'd17:   m = mi(M_CROSS, R_V,   R_H,   R_K);
      5'd18:   m = mi(M_DOT,   R_DOT, R_U,   R_V);
      5'd19:   m = mi(M_FNEG,  R_DOT, R_DOT, R_DOT);
      5'd20:   m = mi(M_VSUB,  R_M,   R_P,   R_B);
      5'd21:   m = mi(M_CROSS, R_W2,  R_E1,  R_M);
      5'd22:   m = mi(M_DOT,   R_DOT, R_U,   R_W2);
      5'd23:   m = mi(M_FNEG,  R_DOT, R_DOT, R_DOT);
      default: m = mi(M_HIT,   R_T,   R_T,   R_T);
    endcase
    return m;
  endfunction

  function automatic uop_t uo(input bop_t kind, input logic [SLOT_W-1:0] dst,
                              input logic [SLOT_W-1:0] ra, input logic [SLOT_W-1:0] rb,
                              input logic last);
    uop_t u;
    u.kind = kind;
    u.dst = dst;
    u.ra = ra;
    u.rb = rb;
    u.last = last;
    return u;
  endfunction

  function automatic uop_t decode(input minst_t m, input logic [SUB_W-1:0] sub);
    uop_t u;
    logic [SLOT_W-1:0] s;
    s = SLOT_W'(sub);
    u = uo(B_HIT, m.dst, m.a, m.b, 1'b1);
    case (m.op)
      M_LOAD: u = uo(B_LD, s, m.a, m.b, sub == SUB_W'(NUM_LOAD - 1));
      M_VSUB: u = uo(B_SUB, m.dst + s, m.a + s, m.b + s, sub == 4'd2);
      M_VADD: u = uo(B_ADD, m.dst + s, m.a + s, m.b + s, sub == 4'd2);
      M_SMUL: u = uo(B_MUL, m.dst + s, m.a + s, m.b, sub == 4'd2);
      M_CROSS: begin
        case (sub)
          4'd0:    u = uo(B_MUL, R_T1, m.a + 6'd1, m.b + 6'd2, 1'b0);
          4'd1:    u = uo(B_MUL, R_T2, m.a + 6'd2, m.b + 6'd1, 1'b0);
          4'd2:    u = uo(B_SUB, m.dst, R_T1, R_T2, 1'b0);
          4'd3:    u = uo(B_MUL, R_T1, m.a + 6'd2, m.b, 1'b0);
          4'd4:    u = uo(B_MUL, R_T2, m.a, m.b + 6'd2, 1'b0);
          4'd5:    u = uo(B_SUB, m.dst + 6'd1, R_T1, R_T2, 1'b0);
          4'd6:    u = uo(B_MUL, R_T1, m.a, m.b + 6'd1, 1'b0);
          4'd7:    u = uo(B_MUL, R_T2, m.a + 6'd1, m.b, 1'b0);
          default: u = uo(B_SUB, m.dst + 6'd2, R_T1, R_T2, 1'b1);
        endcase
      end
      M_DOT: begin
        case (sub)
          4'd0:    u = uo(B_MUL, R_T1, m.a, m.b, 1'b0);
          4'd1:    u = uo(B_MUL, R_T2, m.a + 6'd1, m.b + 6'd1, 1'b0);
          4'd2:    u = uo(B_ADD, R_T1, R_T1, R_T2, 1'b0);
          4'd3:    u = uo(B_MUL, R_T2, m.a + 6'd2, m.b + 6'd2, 1'b0);
          default: u = uo(B_ADD, m.dst, R_T1, R_T2, 1'b1);
        endcase
      end
      M_FNN:   u = uo(B_FNN, m.dst, m.a, m.b, 1'b1);
      M_FNEG:  u = uo(B_FNEG, m.dst, m.a, m.b, 1'b1);
      M_DIV:   u = uo(B_DIV, m.dst, m.a, m.b, 1'b1);
      default: u = uo(B_HIT, m.dst, m.a, m.b, 1'b1);
    endcase
    return u;
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

endpackage

@@ rtl/core/rtnh_if.sv @@
interface rtnh_tri_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] a_x;
  logic signed [COORD_WIDTH-1:0] a_y;
  logic signed [COORD_WIDTH-1:0] a_z;
  logic signed [COORD_WIDTH-1:0] b_x;
  logic signed [COORD_WIDTH-1:0] b_y;
  logic signed [COORD_WIDTH-1:0] b_z;
  logic signed [COORD_WIDTH-1:0] c_x;
  logic signed [COORD_WIDTH-1:0] c_y;
  logic signed [COORD_WIDTH-1:0] c_z;
  logic                          last_triangle;
  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  last_triangle, input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                last_triangle, output ready);
endinterface

interface rtnh_cfg_if #(parameter int COORD_WIDTH = 32);
  logic                              valid;
  logic                              ready;
  logic [rtnh_pkg::CFG_IDX_W-1:0]    index;
  logic signed [COORD_WIDTH-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface rtnh_res_if;
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic [rtnh_pkg::DIST_OUT_W-1:0]   nearest_distance;
  modport source (output valid, hit, nearest_distance, input ready);
  modport sink (input valid, hit, nearest_distance, output ready);
endinterface

@@ rtl/core/ray_triangle_nearest_hit_top.sv @@
// The next triangle is taken only after the current one finishes, whether it reaches the
// last inside test or is culled.
// Every step goes through one operand memory and one 32x32 multiplier used three
// times per 64-bit product; the distance divider retires one bit a cycle.
// Reset is synchronous: ray registers clear to zero, the nearest distance returns to
// 10000.0, the hit flag and the output valid flag clear.
module ray_triangle_nearest_hit_top #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  rtnh_tri_if.sink    tri_in,
  rtnh_cfg_if.sink    cfg_in,
  rtnh_res_if.source  res_out
);

  localparam int QW = 64 + FRAC_BITS;
  localparam int CNT_W = $clog2(QW + 1);
  localparam int DIST_W = (COORD_WIDTH > FRAC_BITS + 14) ? COORD_WIDTH : FRAC_BITS + 14;
  localparam logic [DIST_W-1:0] DIST_CAP = DIST_W'(64'(rtnh_pkg::DIST_INT) << FRAC_BITS);
  localparam int T_W = COORD_WIDTH - 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOAD = 7'b0000010,
    S_READ = 7'b0000100,
    S_EXEC = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t                        state;
  logic [rtnh_pkg::PC_W-1:0]     pc;
  logic [rtnh_pkg::SUB_W-1:0]    sub;
  logic [1:0]                    mph;
  logic [63:0]                   acc;
  logic [63:0]                   rem;
  logic [QW-1:0]                 quo;
  logic [63:0]                   dsr;
  logic [CNT_W-1:0]              cnt;
  logic [T_W-1:0]                t_reg;
  logic [DIST_W-1:0]             best;
  logic                          any_hit;
  logic                          last_q;
  logic                          found;
  logic [COORD_WIDTH-1:0]        vtx [rtnh_pkg::NUM_VTX];
  logic [COORD_WIDTH-1:0]        cfg [rtnh_pkg::NUM_CFG];
  logic [63:0]                   mem [2**rtnh_pkg::SLOT_W];
  logic [63:0]                   rda;
  logic [63:0]                   rdb;
  logic                          out_valid;
  logic                          out_hit;
  logic [rtnh_pkg::DIST_OUT_W-1:0] out_dist;

  rtnh_pkg::uop_t                uop;
  logic [COORD_WIDTH-1:0]        load_raw;
  logic [63:0]                   load_val;
  logic [31:0]                   mx;
  logic [31:0]                   my;
  logic [63:0]                   mprod;
  logic [64:0]                   shifted;
  logic [64:0]                   diff;
  logic                          ge;
  logic                          sat;
  logic [T_W-1:0]                t_new;
  logic                          we;
  logic [63:0]                   wd;
  logic [63:0]                   best64;

  assign uop = rtnh_pkg::decode(rtnh_pkg::prog(pc), sub);

  always_comb begin
    if (sub < rtnh_pkg::SUB_W'(rtnh_pkg::NUM_VTX)) begin
      load_raw = vtx[sub];
    end else begin
      load_raw = cfg[3'(sub - rtnh_pkg::SUB_W'(rtnh_pkg::NUM_VTX))];
    end
  end
  assign load_val = {{(64-COORD_WIDTH){load_raw[COORD_WIDTH-1]}}, load_raw};

  always_comb begin
    case (mph)
      2'd1:    begin mx = rda[31:0];  my = rdb[63:32]; end
      2'd2:    begin mx = rda[63:32]; my = rdb[31:0];  end
      default: begin mx = rda[31:0];  my = rdb[31:0];  end
    endcase
  end
  assign mprod = {32'd0, mx} * {32'd0, my};

  assign shifted = {rem, quo[QW-1]};
  assign diff = shifted - {1'b0, dsr};
  assign ge = shifted >= {1'b0, dsr};
  assign sat = |quo[QW-1:T_W];
  assign t_new = sat ? '1 : quo[T_W-1:0];

  always_comb begin
    we = 1'b0;
    wd = '0;
    case (state)
      S_LOAD: begin
        we = 1'b1;
        wd = load_val;
      end
      S_EXEC: begin
        if (uop.kind == rtnh_pkg::B_SUB) begin
          we = 1'b1;
          wd = rda - rdb;
        end else if (uop.kind == rtnh_pkg::B_ADD) begin
          we = 1'b1;
          wd = rda + rdb;
        end
      end
      S_MUL: begin
        we = (mph == 2'd3);
        wd = 64'($signed(acc) >>> FRAC_BITS);
      end
      S_DIV: begin
        we = (cnt == '0) && (t_new != '0);
        wd = 64'(t_new);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[uop.dst] <= wd;
    end
    if (state == S_READ) begin
      rda <= mem[uop.ra];
      rdb <= mem[uop.rb];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rtnh_pkg::NUM_CFG; i++) begin
        cfg[i] <= '0;
      end
    end else if (cfg_in.valid && cfg_in.index <= rtnh_pkg::CFG_DIR_Z) begin
      cfg[cfg_in.index] <= cfg_in.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc <= '0;
      sub <= '0;
      mph <= '0;
      cnt <= '0;
      best <= DIST_CAP;
      any_hit <= 1'b0;
      found <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (res_out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (tri_in.valid) begin
            vtx[0] <= tri_in.a_x;
            vtx[1] <= tri_in.a_y;
            vtx[2] <= tri_in.a_z;
            vtx[3] <= tri_in.b_x;
            vtx[4] <= tri_in.b_y;
            vtx[5] <= tri_in.b_z;
            vtx[6] <= tri_in.c_x;
            vtx[7] <= tri_in.c_y;
            vtx[8] <= tri_in.c_z;
            last_q <= tri_in.last_triangle;
            pc <= '0;
            sub <= '0;
            found <= 1'b0;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (uop.last) begin
            sub <= '0;
            pc <= pc + 1'b1;
            state <= S_READ;
          end else begin
            sub <= sub + 1'b1;
          end
        end
        S_READ: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          case (uop.kind)
            rtnh_pkg::B_MUL: begin
              acc <= mprod;
              mph <= 2'd1;
              state <= S_MUL;
            end
            rtnh_pkg::B_DIV: begin
              rem <= '0;
              quo <= {rtnh_pkg::mag64(rda), {FRAC_BITS{1'b0}}};
              dsr <= rtnh_pkg::mag64(rdb);
              cnt <= CNT_W'(QW);
              state <= S_DIV;
            end
            rtnh_pkg::B_FNN: begin
              if (!rda[63]) begin
                state <= S_DONE;
              end else begin
                pc <= pc + 1'b1;
                state <= S_READ;
              end
            end
            rtnh_pkg::B_FNEG: begin
              if (rda[63]) begin
                state <= S_DONE;
              end else begin
                pc <= pc + 1'b1;
                state <= S_READ;
              end
            end
            rtnh_pkg::B_HIT: begin
              found <= 1'b1;
              any_hit <= 1'b1;
              if (DIST_W'(t_reg) < best) begin
                best <= DIST_W'(t_reg);
              end
              state <= S_DONE;
            end
            default: begin
              if (uop.last) begin
                sub <= '0;
                pc <= pc + 1'b1;
              end else begin
                sub <= sub + 1'b1;
              end
              state <= S_READ;
            end
          endcase
        end
        S_MUL: begin
          if (mph != 2'd3) begin
            acc <= acc + (mprod << 32);
            mph <= mph + 1'b1;
          end else begin
            mph <= '0;
            if (uop.last) begin
              sub <= '0;
              pc <= pc + 1'b1;
            end else begin
              sub <= sub + 1'b1;
            end
            state <= S_READ;
          end
        end
        S_DIV: begin
          if (cnt != '0) begin
            rem <= ge ? diff[63:0] : shifted[63:0];
            quo <= {quo[QW-2:0], ge};
            cnt <= cnt - 1'b1;
          end else if (t_new == '0) begin
            state <= S_DONE;
          end else begin
            t_reg <= t_new;
            pc <= pc + 1'b1;
            state <= S_READ;
          end
        end
        S_DONE: begin
          if (!last_q) begin
            state <= S_IDLE;
          end else if (!out_valid || res_out.ready) begin
            out_valid <= 1'b1;
            out_hit <= any_hit;
            out_dist <= any_hit ? best64[rtnh_pkg::DIST_OUT_W-1:0] : '0;
            best <= DIST_CAP;
            any_hit <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign best64 = 64'(best);
  assign tri_in.ready = (state == S_IDLE);
  assign cfg_in.ready = 1'b1;
  assign res_out.valid = out_valid;
  assign res_out.hit = out_hit;
  assign res_out.nearest_distance = out_dist;

  a_res_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE) && $past(last_q))
    else $error("result raised without a finished last triangle");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (dsr != '0))
    else $error("divider running with a zero divisor");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_hit) |-> (out_dist == '0))
    else $error("miss result carries a nonzero distance");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ || state == S_EXEC) |-> (pc <= rtnh_pkg::PC_LAST))
    else $error("sequencer ran past the end of the program");

  a_found_best: assert property (@(posedge clk) disable iff (rst)
    $rose(found) |-> any_hit && (best <= DIST_CAP))
    else $error("hit recorded without updating the running state");

endmodule
